FILE: hdl/llb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package llb_pkg;

	// Parameter defaults for the top level.
	localparam int HISTORY_DEPTH_DEF = 4;
	localparam int TICK_WIDTH_DEF    = 32;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE_TONE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_DELAY = 3'd5;

	// Register reset values.
	localparam logic [7:0]  BASE_TONE_RST   = 8'd21;
	localparam logic [7:0]  PULSE_LOW_RST   = 8'd4;
	localparam logic [7:0]  PULSE_HIGH_RST  = 8'd8;
	localparam logic [15:0] WINDOW_LOW_RST  = 16'd125;
	localparam logic [15:0] WINDOW_HIGH_RST = 16'd500;
	localparam logic [15:0] ALARM_DELAY_RST = 16'd3750;

	// Mode codes.
	localparam logic [1:0] MODE_CONNECTED    = 2'd0;
	localparam logic [1:0] MODE_DISCONNECTED = 2'd1;
	localparam logic [1:0] MODE_POWER_OFF    = 2'd2;

	// A run of the beep level is closed when it reaches this length.
	localparam logic [7:0] RUN_LIMIT = 8'd254;

	typedef struct packed {
		logic [7:0]  base_tone;
		logic [7:0]  pulse_low;
		logic [7:0]  pulse_high;
		logic [15:0] window_low;
		logic [15:0] window_high;
		logic [15:0] alarm_delay;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       beep_on;
		logic [7:0] tone;
		logic       led_on;
		logic       turn_off_seen;
		logic       alarm_due;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/llb_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one sample per tick.
interface llb_item_if;
	logic valid;
	logic ready;
	logic link_present;
	logic beep_request;

	modport source (output valid, output link_present, output beep_request, input ready);
	modport sink (input valid, input link_present, input beep_request, output ready);
endinterface

// Result channel: one result per sample.
interface llb_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       beep_on;
	logic [7:0] tone;
	logic       led_on;
	logic       turn_off_seen;
	logic       alarm_due;

	modport source (output valid, output mode, output beep_on, output tone,
		output led_on, output turn_off_seen, output alarm_due, input ready);
	modport sink (input valid, input mode, input beep_on, input tone,
		input led_on, input turn_off_seen, input alarm_due, output ready);
endinterface

`default_nettype wire

FILE: hdl/llb_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module llb_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [llb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [llb_pkg::CFG_DATA_W-1:0] cfg_data,
	output llb_pkg::cfg_t                      cfg
);
	import llb_pkg::*;

	cfg_t cfg_q;

	// Register file; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_tone   <= BASE_TONE_RST;
			cfg_q.pulse_low   <= PULSE_LOW_RST;
			cfg_q.pulse_high  <= PULSE_HIGH_RST;
			cfg_q.window_low  <= WINDOW_LOW_RST;
			cfg_q.window_high <= WINDOW_HIGH_RST;
			cfg_q.alarm_delay <= ALARM_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_TONE:   cfg_q.base_tone   <= cfg_data[7:0];
				REG_PULSE_LOW:   cfg_q.pulse_low   <= cfg_data[7:0];
				REG_PULSE_HIGH:  cfg_q.pulse_high  <= cfg_data[7:0];
				REG_WINDOW_LOW:  cfg_q.window_low  <= cfg_data;
				REG_WINDOW_HIGH: cfg_q.window_high <= cfg_data;
				REG_ALARM_DELAY: cfg_q.alarm_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/llb_core.sv
`timescale 1ns / 1ps
`default_nettype none

module llb_core #(
	parameter int HISTORY_DEPTH = llb_pkg::HISTORY_DEPTH_DEF,
	parameter int TICK_WIDTH    = llb_pkg::TICK_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire llb_pkg::cfg_t cfg,
	llb_item_if.sink           item,
	input  wire logic          room,
	output logic               push,
	output llb_pkg::res_t      res
);
	import llb_pkg::*;

	logic [1:0]            mode_q, mode_n;
	logic [TICK_WIDTH-1:0] elapsed_q, elapsed_mid, elapsed_n;
	logic [7:0]            hist_q [HISTORY_DEPTH];
	logic [7:0]            hist_n [HISTORY_DEPTH];
	logic                  last_q, last_n;
	logic                  flag_q, flag_n;
	logic                  win_old, win_new, all_pulse;
	logic [TICK_WIDTH-1:0] wl, wh, delay;

	assign item.ready = room;
	assign push       = item.valid & room;

	assign wl    = TICK_WIDTH'(cfg.window_low);
	assign wh    = TICK_WIDTH'(cfg.window_high);
	assign delay = TICK_WIDTH'(cfg.alarm_delay);

	// Next state and result for the sample on the input channel.
	always_comb begin
		mode_n      = mode_q;
		elapsed_mid = elapsed_q;
		hist_n      = hist_q;
		last_n      = last_q;
		flag_n      = flag_q;
		all_pulse   = 1'b1;
		res         = '0;

		win_old = (elapsed_q > wl) && (elapsed_q < wh);

		// Mode transition.
		if (item.link_present) begin
			if (mode_q != MODE_CONNECTED) begin
				mode_n      = MODE_CONNECTED;
				elapsed_mid = '0;
			end
		end else if (mode_q == MODE_CONNECTED) begin
			mode_n      = (win_old || flag_q) ? MODE_POWER_OFF : MODE_DISCONNECTED;
			elapsed_mid = '0;
		end

		win_new   = (elapsed_mid > wl) && (elapsed_mid < wh);
		elapsed_n = elapsed_mid;

		// Action of the new mode.
		case (mode_n)
			MODE_CONNECTED: begin
				res.beep_on = item.beep_request;
				res.tone    = item.beep_request ? cfg.base_tone : 8'd0;
				res.led_on  = win_new | item.beep_request | flag_q;

				// Close the open run on a level change or at the run limit.
				if ((last_q != item.beep_request) || (hist_q[0] == RUN_LIMIT)) begin
					for (int i = 1; i < HISTORY_DEPTH; i++) begin
						hist_n[i] = hist_q[i-1];
					end
					hist_n[0] = 8'd0;
					last_n    = item.beep_request;
				end

				// Closed runs must all be strictly inside the pulse bounds.
				for (int i = 1; i < HISTORY_DEPTH; i++) begin
					if (!((hist_n[i] > cfg.pulse_low) && (hist_n[i] < cfg.pulse_high))) begin
						all_pulse = 1'b0;
					end
				end
				flag_n = all_pulse;

				if (elapsed_mid != '1) begin
					elapsed_n = elapsed_mid + TICK_WIDTH'(1);
				end
				hist_n[0] = hist_n[0] + 8'd1;
			end
			MODE_DISCONNECTED: begin
				res.alarm_due = elapsed_mid > delay;
				if (elapsed_mid != '1) begin
					elapsed_n = elapsed_mid + TICK_WIDTH'(1);
				end
			end
			default: ;
		endcase

		res.mode          = mode_n;
		res.turn_off_seen = flag_n;
	end

	// State update on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_DISCONNECTED;
			elapsed_q <= '0;
			last_q    <= 1'b0;
			flag_q    <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= 8'd0;
			end
		end else if (push) begin
			mode_q    <= mode_n;
			elapsed_q <= elapsed_n;
			last_q    <= last_n;
			flag_q    <= flag_n;
			hist_q    <= hist_n;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/llb_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module llb_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire llb_pkg::res_t res,
	output logic               room,
	llb_result_if.source       result
);
	import llb_pkg::*;

	logic [1:0] count_q;
	res_t       head_q, tail_q;
	logic       pop;

	assign pop          = result.valid & result.ready;
	assign room         = (count_q != 2'd2);
	assign result.valid = (count_q != 2'd0);

	assign result.mode          = head_q.mode;
	assign result.beep_on       = head_q.beep_on;
	assign result.tone          = head_q.tone;
	assign result.led_on        = head_q.led_on;
	assign result.turn_off_seen = head_q.turn_off_seen;
	assign result.alarm_due     = head_q.alarm_due;

	// Occupancy of the two-entry buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Payload: the head is always the oldest result.
	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= (push && (count_q == 2'd1)) ? res : tail_q;
			if (push && (count_q == 2'd2)) begin
				tail_q <= res;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= res;
			end else begin
				tail_q <= res;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/link_loss_beeper_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Link-loss beeper monitor. Each transfer on the item channel is one 16 ms tick
// carrying the connection sense and the beep request; each yields exactly one
// transfer on the result channel with the mode (connected, disconnected, power
// off), tone drive, LED level, turn-off flag and alarm flag. The block takes one
// item every clock cycle while the output buffer has room; the mode machine, run
// history and tick counter update on the transfer, and the result goes into a
// two-entry output buffer, so the item channel stays ready while one result waits
// to be taken. Configuration registers (index 0 base_tone, 1 pulse_low,
// 2 pulse_high, 3 window_low, 4 window_high, 5 alarm_delay) are written by the
// user through cfg_we/cfg_index/cfg_data while idle; the block does not check it.
module link_loss_beeper_monitor #(
	parameter int HISTORY_DEPTH = llb_pkg::HISTORY_DEPTH_DEF,
	parameter int TICK_WIDTH    = llb_pkg::TICK_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	llb_item_if.sink                            item,
	llb_result_if.source                        result,
	input  wire logic                           cfg_we,
	input  wire logic [llb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [llb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import llb_pkg::*;

	cfg_t cfg;
	res_t res;
	logic push;
	logic room;

	// Configuration registers.
	llb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Mode machine and run-length tracking.
	llb_core #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.TICK_WIDTH    (TICK_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.room   (room),
		.push   (push),
		.res    (res)
	);

	// Result buffer.
	llb_out_buf u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.room   (room),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import llb_pkg::*;

	localparam int HIST_D = HISTORY_DEPTH_DEF;
	localparam int TICK_W = TICK_WIDTH_DEF;
	localparam int WATCHDOG_LIMIT = 1000;

	// One tick sample as it goes onto the item channel.
	typedef struct packed {
		logic link;
		logic beep;
	} tick_in_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	llb_item_if item_bus();
	llb_result_if result_bus();

	link_loss_beeper_monitor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus.sink),
		.result(result_bus.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Ticks waiting to be sent and results waiting to be received.
	tick_in_t pending_ticks[$];
	res_t expected_results[$];
	int unsigned ticks_queued = 0;
	int unsigned errors = 0;

	// Local copy of the monitor state and its registers.
	cfg_t model_cfg;
	logic [1:0] mon_mode;
	logic [TICK_W-1:0] mon_ticks;
	logic [7:0] run_len[HIST_D];
	logic last_beep;
	logic off_flag;

	// Sender burst and receiver stall bookkeeping.
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_count = 0;
	int unsigned stall_style = 0;
	int unsigned quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic uptime_in_window();
		return mon_ticks > model_cfg.window_low && mon_ticks < model_cfg.window_high;
	endfunction

	function automatic void count_tick();
		if (mon_ticks != '1)
			mon_ticks = mon_ticks + TICK_W'(1);
	endfunction

	// Advance the monitor state by one tick and return the result it produces.
	function automatic res_t predict_tick(input logic link, input logic beep);
		res_t r;
		logic all_pulse;
		r = '0;

		// Mode transition first.
		if (link) begin
			if (mon_mode != MODE_CONNECTED) begin
				mon_mode = MODE_CONNECTED;
				mon_ticks = '0;
			end
		end else if (mon_mode == MODE_CONNECTED) begin
			mon_mode = (uptime_in_window() || off_flag) ? MODE_POWER_OFF : MODE_DISCONNECTED;
			mon_ticks = '0;
		end

		// Then the action of the new mode.
		if (mon_mode == MODE_CONNECTED) begin
			r.beep_on = beep;
			r.tone = beep ? model_cfg.base_tone : 8'd0;
			r.led_on = uptime_in_window() || beep || off_flag;
			if (last_beep != beep || run_len[0] == RUN_LIMIT) begin
				for (int i = HIST_D - 1; i > 0; i--)
					run_len[i] = run_len[i-1];
				run_len[0] = 8'd0;
				last_beep = beep;
			end
			all_pulse = 1'b1;
			for (int i = 1; i < HIST_D; i++)
				if (!(run_len[i] > model_cfg.pulse_low && run_len[i] < model_cfg.pulse_high))
					all_pulse = 1'b0;
			off_flag = all_pulse;
			count_tick();
			run_len[0] = run_len[0] + 8'd1;
		end else if (mon_mode == MODE_DISCONNECTED) begin
			r.alarm_due = mon_ticks > model_cfg.alarm_delay;
			count_tick();
		end

		r.mode = mon_mode;
		r.turn_off_seen = off_flag;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	function automatic void push_tick(input logic link, input logic beep);
		tick_in_t t;
		t.link = link;
		t.beep = beep;
		pending_ticks.push_back(t);
		ticks_queued++;
	endfunction

	// Connected length, often placed on an edge of the uptime window.
	function automatic int pick_uptime();
		int v;
		case ($urandom_range(0, 11))
			0: v = int'(model_cfg.window_low);
			1: v = int'(model_cfg.window_low) + 1;
			2: v = int'(model_cfg.window_high) - 1;
			3: v = int'(model_cfg.window_high);
			default: v = $urandom_range(1, 24);
		endcase
		if (v < 1 || v > 520)
			v = $urandom_range(1, 24);
		return v;
	endfunction

	// Run length of the beep level, mostly near or inside the pulse bounds.
	function automatic int pick_run();
		int lo;
		int hi;
		int v;
		lo = int'(model_cfg.pulse_low);
		hi = int'(model_cfg.pulse_high);
		case ($urandom_range(0, 4))
			0: v = lo;
			1: v = lo + 1;
			2: v = hi - 1;
			3: v = hi;
			default: v = (hi - lo > 2) ? $urandom_range(lo + 1, hi - 1) : $urandom_range(1, 10);
		endcase
		if (v < 1 || v > 30)
			v = $urandom_range(1, 10);
		return v;
	endfunction

	// A connected stretch with a beep pattern, then usually a link loss; or plain noise.
	function automatic void add_session();
		int kind;
		int up;
		int len;
		int lim;
		logic lvl;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// Plain noise on both inputs.
			len = $urandom_range(1, 10);
			repeat (len) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			return;
		end
		up = pick_uptime();
		lvl = 1'($urandom_range(0, 1));
		if (kind <= 5) begin
			while (up > 0) begin
				len = pick_run();
				while (len > 0 && up > 0) begin
					push_tick(1'b1, lvl);
					len--;
					up--;
				end
				lvl = ~lvl;
			end
		end else begin
			repeat (up) begin
				if ($urandom_range(0, 3) == 0)
					lvl = ~lvl;
				push_tick(1'b1, lvl);
			end
		end
		if ($urandom_range(0, 4) == 0)
			return;
		lim = (model_cfg.alarm_delay <= 16'd40) ? int'(model_cfg.alarm_delay) + 4 : 20;
		repeat ($urandom_range(1, lim)) push_tick(1'b0, 1'($urandom_range(0, 1)));
	endfunction

	function automatic void run_random(input int unsigned budget);
		int unsigned start;
		start = ticks_queued;
		while (ticks_queued - start < budget)
			add_session();
	endfunction

	// Wait until every tick has been sent and every result received.
	task automatic wait_idle();
		while (pending_ticks.size() != 0 || expected_results.size() != 0 || item_bus.valid)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Write all register indexes in turn, the two unused ones included.
	task automatic apply_config(input cfg_t c);
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] d;
		@(posedge clk);
		for (int i = 0; i < 8; i++) begin
			idx = CFG_IDX_W'(i);
			case (idx)
				REG_BASE_TONE: d = {8'($urandom), c.base_tone};
				REG_PULSE_LOW: d = {8'($urandom), c.pulse_low};
				REG_PULSE_HIGH: d = {8'($urandom), c.pulse_high};
				REG_WINDOW_LOW: d = c.window_low;
				REG_WINDOW_HIGH: d = c.window_high;
				REG_ALARM_DELAY: d = c.alarm_delay;
				default: d = 16'($urandom);
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= d;
			@(posedge clk);
			case (idx)
				REG_BASE_TONE: model_cfg.base_tone = d[7:0];
				REG_PULSE_LOW: model_cfg.pulse_low = d[7:0];
				REG_PULSE_HIGH: model_cfg.pulse_high = d[7:0];
				REG_WINDOW_LOW: model_cfg.window_low = d;
				REG_WINDOW_HIGH: model_cfg.window_high = d;
				REG_ALARM_DELAY: model_cfg.alarm_delay = d;
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Small working settings that let every path occur within short sessions.
	function automatic cfg_t small_config();
		cfg_t c;
		c.base_tone = 8'($urandom);
		c.pulse_low = 8'($urandom_range(0, 4));
		c.pulse_high = c.pulse_low + 8'($urandom_range(2, 6));
		c.window_low = 16'($urandom_range(0, 12));
		c.window_high = c.window_low + 16'($urandom_range(2, 25));
		c.alarm_delay = 16'($urandom_range(0, 20));
		return c;
	endfunction

	// Sender: bursts of random length with random gaps.
	always @(posedge clk) begin
		tick_in_t t;
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else if (!item_bus.valid || item_bus.ready) begin
			if (gap_left != 0 || pending_ticks.size() == 0) begin
				item_bus.valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				t = pending_ticks.pop_front();
				item_bus.valid <= 1'b1;
				item_bus.link_present <= t.link;
				item_bus.beep_request <= t.beep;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Receiver: the stall pattern is drawn anew whenever the stall counter runs out.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (stall_count == 0) begin
				stall_style = $urandom_range(0, 3);
				stall_count = 48;
			end
			stall_count--;
			case (stall_style)
				0: result_bus.ready <= 1'b1;
				1: result_bus.ready <= 1'($urandom_range(0, 1));
				2: result_bus.ready <= (stall_count % 4 == 0);
				default: result_bus.ready <= (stall_count % 8 >= 5);
			endcase
		end
	end

	// Predict on each tick transfer, then check each result transfer.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready)
				expected_results.push_back(predict_tick(item_bus.link_present,
					item_bus.beep_request));
			if (result_bus.valid && result_bus.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no tick outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("mode", want.mode, result_bus.mode);
					check_field("beep_on", want.beep_on, result_bus.beep_on);
					check_field("tone", want.tone, result_bus.tone);
					check_field("led_on", want.led_on, result_bus.led_on);
					check_field("turn_off_seen", want.turn_off_seen, result_bus.turn_off_seen);
					check_field("alarm_due", want.alarm_due, result_bus.alarm_due);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_bus.valid = 1'b0;
		item_bus.link_present = 1'b0;
		item_bus.beep_request = 1'b0;
		result_bus.ready = 1'b0;

		model_cfg = {BASE_TONE_RST, PULSE_LOW_RST, PULSE_HIGH_RST,
			WINDOW_LOW_RST, WINDOW_HIGH_RST, ALARM_DELAY_RST};
		mon_mode = MODE_DISCONNECTED;
		mon_ticks = '0;
		for (int i = 0; i < HIST_D; i++)
			run_len[i] = 8'd0;
		last_beep = 1'b0;
		off_flag = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: disconnected after reset, then a turn-off pulse pattern
		// of runs 5, 6 and 7 ticks, link loss into power off, and a return.
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		repeat (5) push_tick(1'b1, 1'b1);
		repeat (6) push_tick(1'b1, 1'b0);
		repeat (7) push_tick(1'b1, 1'b1);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b0);
		push_tick(1'b1, 1'b1);
		wait_idle();

		// All registers at zero.
		c = '0;
		apply_config(c);
		run_random(20);
		wait_idle();

		// All registers at their maximum.
		c = '1;
		apply_config(c);
		run_random(20);
		wait_idle();

		// Crossed bounds: nothing lies strictly between them.
		c = small_config();
		c.pulse_low = 8'($urandom_range(6, 12));
		c.pulse_high = 8'($urandom_range(0, c.pulse_low - 1));
		c.window_low = 16'($urandom_range(10, 30));
		c.window_high = 16'($urandom_range(0, c.window_low));
		apply_config(c);
		run_random(20);
		wait_idle();

		// One run that closes at the length limit followed by two runs of
		// five ticks; all three lie inside wide pulse bounds and set the flag.
		c = small_config();
		c.pulse_low = 8'd4;
		c.pulse_high = 8'd255;
		apply_config(c);
		push_tick(1'b1, 1'b0);
		repeat (259) push_tick(1'b1, 1'b1);
		repeat (5) push_tick(1'b1, 1'b0);
		push_tick(1'b1, 1'b1);
		repeat (4) push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b1);
		wait_idle();

		// Several small working settings.
		repeat (3) begin
			apply_config(small_config());
			run_random(20);
			wait_idle();
		end

		repeat (4) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			errors++;
		end
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
